// ===== hw/rtl/swtt_pkg.sv =====
// ----------------------------------------------------------------------------
// swtt_pkg
// Shared types and constants of the software timer task table.
// ----------------------------------------------------------------------------
package swtt_pkg;

  localparam int unsigned Slots   = 20;
  localparam int unsigned KindW   = 2;
  localparam int unsigned PeriodW = 16;
  localparam int unsigned TagW    = 8;
  localparam int unsigned SlotW   = 5;

  typedef enum logic [KindW-1:0] {
    KIND_TICK    = 2'd0,
    KIND_ADD     = 2'd1,
    KIND_REMOVE  = 2'd2,
    KIND_PROCESS = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } state_e;

  typedef struct packed {
    kind_e              kind;
    logic [PeriodW-1:0] period;
    logic               repeat_req;
    logic [TagW-1:0]    handler_tag;
    logic [SlotW-1:0]   slot;
  } cmd_t;

  typedef struct packed {
    logic active;
    logic claimed;
  } tok_t;

endpackage

// ===== hw/rtl/swtt_if.sv =====
// ----------------------------------------------------------------------------
// swtt_in_if / swtt_out_if
// Valid/ready channels carrying commands into and results out of the table.
// ----------------------------------------------------------------------------
interface swtt_in_if;
  logic                           valid;
  logic                           ready;
  logic [swtt_pkg::KindW-1:0]     kind;
  logic [swtt_pkg::PeriodW-1:0]   period;
  logic                           repeat_req;
  logic [swtt_pkg::TagW-1:0]      handler_tag;
  logic [swtt_pkg::SlotW-1:0]     slot;

  modport source (output valid, kind, period, repeat_req, handler_tag, slot, input ready);
  modport sink   (input valid, kind, period, repeat_req, handler_tag, slot, output ready);
endinterface

interface swtt_out_if;
  logic                           valid;
  logic                           ready;
  logic [swtt_pkg::SlotW-1:0]     slot_id;
  logic [swtt_pkg::TagW-1:0]      fire_tag;
  logic                           fired;
  logic                           last;

  modport source (output valid, slot_id, fire_tag, fired, last, input ready);
  modport sink   (input valid, slot_id, fire_tag, fired, last, output ready);
endinterface

// ===== hw/rtl/swtt_cell.sv =====
// ----------------------------------------------------------------------------
// swtt_cell
// One timer slot: holds its state and acts on the command token as it passes.
// ----------------------------------------------------------------------------
module swtt_cell #(
  parameter int unsigned IdxW  = $clog2(swtt_pkg::Slots),
  parameter int unsigned INDEX = 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        adv_i,
  input  swtt_pkg::cmd_t              cmd_i,
  input  swtt_pkg::tok_t              tok_i,
  input  logic [IdxW-1:0]             id_i,
  output swtt_pkg::tok_t              tok_o,
  output logic [IdxW-1:0]             id_o,
  output logic                        fire_o,
  output logic [swtt_pkg::TagW-1:0]   tag_o
);

  swtt_pkg::tok_t                 tok_q;
  logic [IdxW-1:0]                id_q;
  logic                           valid_q, valid_d;
  logic                           ready_q, ready_d;
  logic [swtt_pkg::PeriodW-1:0]   count_q, count_d;
  logic [swtt_pkg::PeriodW-1:0]   period_q;
  logic                           repeat_q;
  logic [swtt_pkg::TagW-1:0]      tag_q;
  logic [swtt_pkg::PeriodW-1:0]   count_inc;
  logic                           claim;
  logic                           act;

  assign act       = tok_q.active && adv_i;
  assign count_inc = count_q + swtt_pkg::PeriodW'(1);
  assign claim     = tok_q.active && (cmd_i.kind == swtt_pkg::KIND_ADD) && !valid_q
                     && !tok_q.claimed;
  assign fire_o    = tok_q.active && (cmd_i.kind == swtt_pkg::KIND_PROCESS)
                     && valid_q && ready_q;
  assign tag_o     = tag_q;

  always_comb begin
    tok_o         = tok_q;
    id_o          = id_q;
    if (claim) begin
      tok_o.claimed = 1'b1;
      id_o          = IdxW'(INDEX);
    end
  end

  always_comb begin
    valid_d = valid_q;
    ready_d = ready_q;
    count_d = count_q;
    if (act) begin
      case (cmd_i.kind)
        swtt_pkg::KIND_TICK: begin
          if (valid_q) begin
            if (count_inc >= period_q) begin
              count_d = '0;
              ready_d = 1'b1;
            end else begin
              count_d = count_inc;
            end
          end
        end
        swtt_pkg::KIND_ADD: begin
          if (claim) begin
            count_d = '0;
            ready_d = 1'b0;
            valid_d = 1'b1;
          end
        end
        swtt_pkg::KIND_REMOVE: begin
          if (32'(cmd_i.slot) == INDEX) begin
            valid_d = 1'b0;
          end
        end
        swtt_pkg::KIND_PROCESS: begin
          if (fire_o) begin
            ready_d = 1'b0;
            if (!repeat_q) begin
              valid_d = 1'b0;
            end
          end
        end
        default: begin
          valid_d = valid_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q   <= '0;
      valid_q <= 1'b0;
      ready_q <= 1'b0;
      count_q <= '0;
    end else begin
      if (adv_i) begin
        tok_q <= tok_i;
      end
      valid_q <= valid_d;
      ready_q <= ready_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      id_q <= id_i;
    end
    if (act && claim) begin
      period_q <= cmd_i.period;
      repeat_q <= cmd_i.repeat_req;
      tag_q    <= cmd_i.handler_tag;
    end
  end

endmodule

// ===== hw/rtl/software_timer_task_table_unit.sv =====
// ----------------------------------------------------------------------------
// software_timer_task_table_unit
// Timer slot table built as a chain of slot cells walked by a command token.
//
// Channels: in_i takes one command (tick, add, remove, process) per
// transaction; out_o returns the results. Tick, add and remove give one
// result with last set; add reports the claimed slot (0 when full). Process
// gives one fired result per valid ready slot in ascending order, then a
// closing result with last set.
// Walk: after a command is taken, a token visits slots 1 to SLOTS-1, one
// cell per cycle while no firing cell holds it, then the closing result is
// loaded; the length of the walk is set by the length of the cell chain.
// The next command is taken once the closing result sits in the output
// register. Slot 0 is reserved and has no cell.
// Reset clears all valid, ready and count bits and the output valid bit.
// A stalled receiver holds the output register; a firing cell then holds
// the token until its result can be loaded.
// ----------------------------------------------------------------------------
module software_timer_task_table_unit #(
  parameter int unsigned SLOTS = swtt_pkg::Slots
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  swtt_in_if.sink         in_i,
  swtt_out_if.source      out_o
);

  localparam int unsigned IdxW = $clog2(SLOTS);

  swtt_pkg::state_e             state_q, state_d;
  swtt_pkg::cmd_t               cmd_q;
  logic [IdxW-1:0]              end_id_q;
  logic                         out_valid_q;
  logic [swtt_pkg::SlotW-1:0]   out_id_q;
  logic [swtt_pkg::TagW-1:0]    out_tag_q;
  logic                         out_fired_q;
  logic                         out_last_q;

  swtt_pkg::tok_t               tok [SLOTS];
  logic [IdxW-1:0]              tid [SLOTS];
  logic [SLOTS-1:1]             fire;
  logic [SLOTS-1:1]             tok_act;
  logic [swtt_pkg::TagW-1:0]    ctag [SLOTS];

  logic                         accept;
  logic                         out_ok;
  logic                         fire_any;
  logic                         adv;
  logic [IdxW-1:0]              fire_id;
  logic [swtt_pkg::TagW-1:0]    fire_tag;
  logic                         tail_done;
  logic                         load_fire;
  logic                         load_close;

  assign in_i.ready = (state_q == swtt_pkg::ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign out_ok     = !out_valid_q || out_o.ready;
  assign fire_any   = |fire;
  assign adv        = !fire_any || out_ok;

  assign tok[0]     = '{active: accept, claimed: 1'b0};
  assign tid[0]     = '0;
  assign ctag[0]    = '0;

  for (genvar g = 1; g < SLOTS; g++) begin : g_cell
    swtt_cell #(
      .IdxW  (IdxW),
      .INDEX (g)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .cmd_i  (cmd_q),
      .tok_i  (tok[g-1]),
      .id_i   (tid[g-1]),
      .tok_o  (tok[g]),
      .id_o   (tid[g]),
      .fire_o (fire[g]),
      .tag_o  (ctag[g])
    );
    assign tok_act[g] = tok[g].active;
  end

  always_comb begin
    fire_id  = '0;
    fire_tag = '0;
    for (int i = 1; i < SLOTS; i++) begin
      if (fire[i]) begin
        fire_id  = fire_id | IdxW'(i);
        fire_tag = fire_tag | ctag[i];
      end
    end
  end

  assign tail_done = tok[SLOTS-1].active && adv;

  always_comb begin
    state_d    = state_q;
    load_fire  = 1'b0;
    load_close = 1'b0;
    case (state_q)
      swtt_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = swtt_pkg::ST_RUN;
        end
      end
      swtt_pkg::ST_RUN: begin
        load_fire = fire_any && out_ok;
        if (tail_done) begin
          state_d = swtt_pkg::ST_FINISH;
        end
      end
      swtt_pkg::ST_FINISH: begin
        if (out_ok) begin
          load_close = 1'b1;
          state_d    = swtt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = swtt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= swtt_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_fire || load_close) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q.kind        <= swtt_pkg::kind_e'(in_i.kind);
      cmd_q.period      <= in_i.period;
      cmd_q.repeat_req  <= in_i.repeat_req;
      cmd_q.handler_tag <= in_i.handler_tag;
      cmd_q.slot        <= in_i.slot;
    end
    if (tail_done) begin
      end_id_q <= tid[SLOTS-1];
    end
    if (load_fire) begin
      out_id_q    <= swtt_pkg::SlotW'(fire_id);
      out_tag_q   <= fire_tag;
      out_fired_q <= 1'b1;
      out_last_q  <= 1'b0;
    end else if (load_close) begin
      out_id_q    <= swtt_pkg::SlotW'(end_id_q);
      out_tag_q   <= '0;
      out_fired_q <= 1'b0;
      out_last_q  <= 1'b1;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.slot_id  = out_id_q;
  assign out_o.fire_tag = out_tag_q;
  assign out_o.fired    = out_fired_q;
  assign out_o.last     = out_last_q;

`ifndef SYNTHESIS
  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok_act))
    else $error("more than one token in the cell chain");

  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == swtt_pkg::ST_IDLE) |-> (tok_act == '0))
    else $error("token in chain while idle");

  a_fire_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_any |-> (state_q == swtt_pkg::ST_RUN) && $onehot(fire))
    else $error("fire outside a walk or from several cells");

  a_fire_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_fired_q && out_last_q))
    else $error("result both fired and last");

  a_close_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_close |=> (state_q == swtt_pkg::ST_IDLE) && out_valid_q && out_last_q)
    else $error("closing result not followed by idle");
`endif

endmodule
